/* design/per_function_completion_tracker_core_macros.svh */
// assertion macros for the per-function completion tracker
// included by the top level; no other dependencies
`ifndef PER_FUNCTION_COMPLETION_TRACKER_CORE_MACROS_SVH
`define PER_FUNCTION_COMPLETION_TRACKER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define PFCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfct assertion failed");
`define PFCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfct assertion failed");
`else
`define PFCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PFCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/pfct_pkg.sv */
// shared types and constants of the per-function completion tracker
// no dependencies
package pfct_pkg;

    localparam int FN_W   = 5;
    localparam int KEY_W  = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCNT_W = 4;
    localparam int DCNT_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER  = 2'd0,
        CMD_COMPLETE  = 2'd1,
        CMD_RESET_ONE = 2'd2,
        CMD_RESET_ALL = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_FUNC = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NO_MATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic free_found;
    } scan_stat_t;

endpackage

/* design/per_function_completion_tracker_core.sv */
// Outstanding transaction ID tracker for NUM_FUNCTIONS functions with CAPACITY slots each.
// A register or complete item scans the slots of the addressed function, which are read one per
// cycle from the single read port of the key store and checked by one shared comparator.
// Reset-one, reset-all and bad-function items skip the scan. in_stall stays high from
// acceptance until the result has been moved into the output register.
// top level; depends on pfct_pkg, pfct_scan, pfct_key_ram and the macro header
`include "per_function_completion_tracker_core_macros.svh"
module per_function_completion_tracker_core
    import pfct_pkg::*;
#(
    parameter int CAPACITY      = 8,
    parameter int NUM_FUNCTIONS = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [FN_W-1:0]   function_id,
    input  logic [KEY_W-1:0]  txn_key,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [OCNT_W-1:0] open_cnt,
    output logic [DCNT_W-1:0] cpl_cnt
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int FNI_W  = (NUM_FUNCTIONS > 1) ? $clog2(NUM_FUNCTIONS) : 1;
    localparam int DEPTH  = NUM_FUNCTIONS * CAPACITY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [FN_W:0]  NUM_FN_V = (FN_W + 1)'(NUM_FUNCTIONS);
    localparam logic [CNT_W-1:0] FULL_V = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [FN_W-1:0]     fn_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [CAPACITY-1:0] valid_reg    [NUM_FUNCTIONS];
    logic [CAPACITY-1:0] valid_next   [NUM_FUNCTIONS];
    logic [DCNT_W-1:0]   done_cnt_reg [NUM_FUNCTIONS];
    logic [DCNT_W-1:0]   done_cnt_next[NUM_FUNCTIONS];
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg,    status_next;
    logic [OCNT_W-1:0]   ocnt_reg,      ocnt_next;
    logic [DCNT_W-1:0]   ccnt_reg,      ccnt_next;

    logic                in_accept;
    logic                in_good;
    logic                fn_good;
    logic [FNI_W-1:0]    fn_idx;
    logic [ADDR_W-1:0]   base_addr;
    logic                scan_start;
    logic                commit;
    logic [CAPACITY-1:0] row_valid;

    logic                rd_en;
    logic [SLOT_W-1:0]   rd_slot;
    logic [KEY_W-1:0]    rd_data;
    scan_stat_t          scan_stat;
    logic [SLOT_W-1:0]   hit_slot;
    logic [SLOT_W-1:0]   free_slot;
    logic [CNT_W-1:0]    used;
    logic                full;
    logic                wr_en;
    logic [CNT_W-1:0]    cnt_val;
    logic                hold_done;
    logic                res_bad;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign in_good    = ({1'b0, function_id} < NUM_FN_V);
    assign fn_good    = ({1'b0, fn_reg} < NUM_FN_V);
    assign fn_idx     = fn_reg[FNI_W-1:0];
    assign base_addr  = ADDR_W'(fn_idx) * ADDR_W'(CAPACITY);
    assign row_valid  = valid_reg[fn_idx];
    assign scan_start = in_accept && in_good
                        && ((cmd_t'(cmd) == CMD_REGISTER) || (cmd_t'(cmd) == CMD_COMPLETE));
    assign commit     = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign full       = (used == FULL_V);
    assign wr_en      = commit && fn_good && (cmd_reg == CMD_REGISTER)
                        && !full && !scan_stat.hit;
    assign hold_done  = (state_reg == S_DONE) && out_valid_reg && out_stall;
    assign res_bad    = out_valid_reg && (status_reg == STAT_BAD_FUNC);

    pfct_scan #(
        .CAPACITY (CAPACITY),
        .SLOT_W   (SLOT_W),
        .CNT_W    (CNT_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .key       (key_reg),
        .row_valid (row_valid),
        .rd_en     (rd_en),
        .rd_slot   (rd_slot),
        .rd_data   (rd_data),
        .stat      (scan_stat),
        .hit_slot  (hit_slot),
        .free_slot (free_slot),
        .used      (used)
    );

    pfct_key_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (base_addr + ADDR_W'(free_slot)),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (base_addr + ADDR_W'(rd_slot)),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = scan_start ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result and table update, applied only on commit
    always_comb
    begin
        valid_next    = valid_reg;
        done_cnt_next = done_cnt_reg;
        status_next   = STAT_OK;
        cnt_val       = '0;
        if (cmd_reg == CMD_RESET_ALL)
        begin
            for (int f = 0; f < NUM_FUNCTIONS; f++)
            begin
                valid_next[f] = '0;
            end
        end
        else if (!fn_good)
        begin
            status_next = STAT_BAD_FUNC;
        end
        else
        begin
            case (cmd_reg)
                CMD_REGISTER:
                begin
                    cnt_val = used;
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else if (!scan_stat.hit)
                    begin
                        valid_next[fn_idx][free_slot] = 1'b1;
                        cnt_val = used + 1'b1;
                    end
                end
                CMD_COMPLETE:
                begin
                    cnt_val = used;
                    if (scan_stat.hit)
                    begin
                        valid_next[fn_idx][hit_slot] = 1'b0;
                        done_cnt_next[fn_idx] = done_cnt_reg[fn_idx] + 1'b1;
                        cnt_val = used - 1'b1;
                    end
                    else
                    begin
                        status_next = STAT_NO_MATCH;
                    end
                end
                default:
                begin
                    valid_next[fn_idx] = '0;
                end
            endcase
        end
        ocnt_next = fn_good ? OCNT_W'(cnt_val) : '0;
        ccnt_next = fn_good ? done_cnt_next[fn_idx] : '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int f = 0; f < NUM_FUNCTIONS; f++)
            begin
                valid_reg[f]    <= '0;
                done_cnt_reg[f] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                valid_reg    <= valid_next;
                done_cnt_reg <= done_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            fn_reg  <= function_id;
            key_reg <= txn_key;
        end
        if (commit)
        begin
            status_reg <= status_next;
            ocnt_reg   <= ocnt_next;
            ccnt_reg   <= ccnt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign open_cnt  = ocnt_reg;
    assign cpl_cnt   = ccnt_reg;

    `PFCT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall)
    `PFCT_ASSERT_IMP(a_scan_done_in_scan, clk, rst_n, scan_stat.done, state_reg == S_SCAN)
    `PFCT_ASSERT_NXT(a_hold_until_free, clk, rst_n, hold_done, state_reg == S_DONE)
    `PFCT_ASSERT_IMP(a_bad_fn_zero, clk, rst_n, res_bad, (ocnt_reg == '0) && (ccnt_reg == '0))

endmodule

/* design/pfct_key_ram.sv */
// key store: one write port, one registered read port
// depends on pfct_pkg
module pfct_key_ram
    import pfct_pkg::*;
#(
    parameter int DEPTH  = 136,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/pfct_scan.sv */
// slot scanner: walks one function's slots through the key store
// with a single shared key comparator; depends on pfct_pkg
module pfct_scan
    import pfct_pkg::*;
#(
    parameter int CAPACITY = 8,
    parameter int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_W-1:0]    key,
    input  logic [CAPACITY-1:0] row_valid,
    output logic                rd_en,
    output logic [SLOT_W-1:0]   rd_slot,
    input  logic [KEY_W-1:0]    rd_data,
    output scan_stat_t          stat,
    output logic [SLOT_W-1:0]   hit_slot,
    output logic [SLOT_W-1:0]   free_slot,
    output logic [CNT_W-1:0]    used
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

    logic              active_reg,    active_next;
    logic [SLOT_W-1:0] rd_slot_reg,   rd_slot_next;
    logic              cmp_vld_reg,   cmp_vld_next;
    logic [SLOT_W-1:0] cmp_slot_reg,  cmp_slot_next;
    logic              hit_reg,       hit_next;
    logic [SLOT_W-1:0] hit_slot_reg,  hit_slot_next;
    logic              free_reg,      free_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    logic [CNT_W-1:0]  used_reg,      used_next;
    logic              done_reg,      done_next;

    always_comb
    begin
        active_next    = active_reg;
        rd_slot_next   = rd_slot_reg;
        cmp_vld_next   = 1'b0;
        cmp_slot_next  = cmp_slot_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        used_next      = used_reg;
        done_next      = 1'b0;
        if (start)
        begin
            active_next  = 1'b1;
            rd_slot_next = '0;
            hit_next     = 1'b0;
            free_next    = 1'b0;
            used_next    = '0;
        end
        else
        begin
            cmp_vld_next  = active_reg;
            cmp_slot_next = rd_slot_reg;
            if (active_reg)
            begin
                if (rd_slot_reg == LAST_SLOT)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    rd_slot_next = rd_slot_reg + 1'b1;
                end
            end
            if (cmp_vld_reg)
            begin
                if (row_valid[cmp_slot_reg])
                begin
                    used_next = used_reg + 1'b1;
                    if (!hit_reg && (rd_data == key))
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = cmp_slot_reg;
                    end
                end
                else if (!free_reg)
                begin
                    free_next      = 1'b1;
                    free_slot_next = cmp_slot_reg;
                end
                if (cmp_slot_reg == LAST_SLOT)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            rd_slot_reg <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            used_reg    <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
            rd_slot_reg <= rd_slot_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            used_reg    <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_slot_reg  <= cmp_slot_next;
        hit_slot_reg  <= hit_slot_next;
        free_slot_reg <= free_slot_next;
    end

    assign rd_en           = active_reg;
    assign rd_slot         = rd_slot_reg;
    assign stat.done       = done_reg;
    assign stat.hit        = hit_reg;
    assign stat.free_found = free_reg;
    assign hit_slot        = hit_slot_reg;
    assign free_slot       = free_slot_reg;
    assign used            = used_reg;

endmodule

/* sim/pfct_checker.sv */
// scoreboard for the per-function completion tracker: watches both channels,
// predicts each result from its own copy of the slot tables and counters, and compares
// depends on pfct_pkg
module pfct_checker
    import pfct_pkg::*;
#(
    parameter int CAPACITY      = 8,
    parameter int NUM_FUNCTIONS = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [FN_W-1:0]   function_id,
    input  logic [KEY_W-1:0]  txn_key,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [STAT_W-1:0] status,
    input  logic [OCNT_W-1:0] open_cnt,
    input  logic [DCNT_W-1:0] cpl_cnt,
    output int                errors,
    output int                pending,
    output int                checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t             st;
        logic [OCNT_W-1:0]   ocnt;
        logic [DCNT_W-1:0]   dcnt;
    } outcome_t;

    bit                slot_used [NUM_FUNCTIONS][CAPACITY];
    logic [KEY_W-1:0]  slot_key  [NUM_FUNCTIONS][CAPACITY];
    logic [DCNT_W-1:0] done_cnt  [NUM_FUNCTIONS];
    outcome_t          outcome_q [$];
    outcome_t          want;
    int                accepted_items = 0;
    int                seen_results = 0;
    int                fail_cnt = 0;

    assign errors  = fail_cnt;
    assign pending = accepted_items - seen_results;
    assign checked = seen_results;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h, want %0h (result %0d)",
                                      name, got, exp_val, seen_results));
    endtask

    function automatic void clear_function(input int f);
        for (int i = 0; i < CAPACITY; i++)
            slot_used[f][i] = 1'b0;
    endfunction

    function automatic outcome_t track_item(input cmd_t c, input logic [FN_W-1:0] f,
                                            input logic [KEY_W-1:0] k);
        outcome_t r;
        bit       good;
        bit       dup;
        bit       hit;
        int       free_idx;
        int       used;
        int       n;
        good     = f < NUM_FUNCTIONS;
        r.st     = STAT_OK;
        dup      = 1'b0;
        hit      = 1'b0;
        free_idx = -1;
        used     = 0;
        n        = 0;
        if (c == CMD_RESET_ALL)
        begin
            for (int g = 0; g < NUM_FUNCTIONS; g++)
                clear_function(g);
        end
        else if (!good)
        begin
            r.st = STAT_BAD_FUNC;
        end
        else if (c == CMD_REGISTER)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (slot_used[f][i])
                begin
                    used++;
                    if (slot_key[f][i] == k)
                        dup = 1'b1;
                end
                else if (free_idx < 0)
                begin
                    free_idx = i;
                end
            end
            if (used >= CAPACITY)
            begin
                r.st = STAT_FULL;
            end
            else if (!dup && free_idx >= 0)
            begin
                slot_used[f][free_idx] = 1'b1;
                slot_key[f][free_idx]  = k;
            end
        end
        else if (c == CMD_COMPLETE)
        begin
            for (int i = 0; i < CAPACITY && !hit; i++)
            begin
                if (slot_used[f][i] && slot_key[f][i] == k)
                begin
                    slot_used[f][i] = 1'b0;
                    hit = 1'b1;
                end
            end
            if (hit)
                done_cnt[f] = done_cnt[f] + 1'b1;
            else
                r.st = STAT_NO_MATCH;
        end
        else
        begin
            clear_function(f);
        end
        if (good)
        begin
            for (int i = 0; i < CAPACITY; i++)
                if (slot_used[f][i])
                    n++;
            r.ocnt = n[OCNT_W-1:0];
            r.dcnt = done_cnt[f];
        end
        else
        begin
            r.ocnt = '0;
            r.dcnt = '0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_FUNCTIONS; g++)
            begin
                clear_function(g);
                done_cnt[g] = '0;
            end
            outcome_q.delete();
            accepted_items <= 0;
            seen_results   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                outcome_q.push_back(track_item(cmd_t'(cmd), function_id, txn_key));
                accepted_items <= accepted_items + 1;
            end
            if (out_valid && !out_stall)
            begin
                seen_results <= seen_results + 1;
                if (outcome_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with no item pending, status %0d",
                                              status));
                end
                else
                begin
                    want = outcome_q.pop_front();
                    compare_field("status", 32'(status), 32'(want.st));
                    compare_field("open_cnt", 32'(open_cnt), 32'(want.ocnt));
                    compare_field("cpl_cnt", cpl_cnt, want.dcnt);
                end
            end
        end
    end

endmodule

/* sim/tb_top.sv */
// top of the completion tracker testbench: clock, reset, directed and random items,
// output stall patterns and the verdict
// depends on pfct_pkg, pfct_checker and the tracker RTL
module tb_top
    import pfct_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY      = 8;
    localparam int NUM_FUNCTIONS = 17;
    localparam int POOL          = 12;
    localparam int PHASE_ITEMS   = 367;
    localparam int HOLD_CYCLES   = 150;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [CMD_W-1:0]  cmd = CMD_REGISTER;
    logic [FN_W-1:0]   function_id = '0;
    logic [KEY_W-1:0]  txn_key = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [STAT_W-1:0] status;
    logic [OCNT_W-1:0] open_cnt;
    logic [DCNT_W-1:0] cpl_cnt;

    int                errors;
    int                pending;
    int                checked;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    bit                hold_req = 1'b0;
    bit                hold_ack = 1'b0;
    int                hold_left = 0;
    int                sent_per_cmd [4] = '{0, 0, 0, 0};
    logic [KEY_W-1:0]  key_pool [NUM_FUNCTIONS][POOL];

    always #4 clk = ~clk;

    per_function_completion_tracker_core #(
        .CAPACITY      (CAPACITY),
        .NUM_FUNCTIONS (NUM_FUNCTIONS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .function_id (function_id),
        .txn_key     (txn_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .open_cnt    (open_cnt),
        .cpl_cnt     (cpl_cnt)
    );

    pfct_checker #(
        .CAPACITY      (CAPACITY),
        .NUM_FUNCTIONS (NUM_FUNCTIONS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .function_id (function_id),
        .txn_key     (txn_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .open_cnt    (open_cnt),
        .cpl_cnt     (cpl_cnt),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked)
    );

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            out_stall <= 1'b1;
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic offer(input cmd_t c, input logic [FN_W-1:0] f, input logic [KEY_W-1:0] k);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        function_id <= f;
        txn_key     <= k;
        sent_per_cmd[c]++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // mostly keys from a small per-function pool so that hits, duplicates and full
    // tables are common
    task automatic random_item();
        int               r;
        logic [FN_W-1:0]  f;
        logic [KEY_W-1:0] k;
        cmd_t             c;
        r = $urandom_range(0, 99);
        if (r < 8)
            f = FN_W'($urandom_range(NUM_FUNCTIONS, 31));
        else if (r < 50)
            f = FN_W'($urandom_range(0, 2));
        else
            f = FN_W'($urandom_range(0, NUM_FUNCTIONS - 1));
        if ($urandom_range(0, 99) < 10)
            k = $urandom;
        else
            k = key_pool[f % NUM_FUNCTIONS][$urandom_range(0, POOL - 1)];
        r = $urandom_range(0, 99);
        if (r < 50)
            c = CMD_REGISTER;
        else if (r < 90)
            c = CMD_COMPLETE;
        else if (r < 98)
            c = CMD_RESET_ONE;
        else
            c = CMD_RESET_ALL;
        offer(c, f, k);
    endtask

    initial
    begin
        foreach (key_pool[f, i])
            key_pool[f][i] = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items
        offer(CMD_REGISTER, 5'd0, 32'h0000_0000);
        offer(CMD_REGISTER, 5'd0, 32'h0000_0000);
        offer(CMD_REGISTER, 5'd0, 32'hFFFF_FFFF);
        offer(CMD_REGISTER, 5'd16, 32'hA5A5_A5A5);
        offer(CMD_REGISTER, 5'd31, 32'h1234_5678);
        offer(CMD_COMPLETE, 5'd17, 32'hFFFF_FFFF);
        offer(CMD_COMPLETE, 5'd0, 32'h1234_5678);
        offer(CMD_COMPLETE, 5'd0, 32'hFFFF_FFFF);
        for (int i = 0; i < CAPACITY; i++)
            offer(CMD_REGISTER, 5'd5, key_pool[5][i]);
        offer(CMD_REGISTER, 5'd5, 32'h5A5A_5A5A);
        offer(CMD_REGISTER, 5'd5, key_pool[5][3]);
        offer(CMD_RESET_ONE, 5'd5, 32'h0000_0000);
        offer(CMD_RESET_ONE, 5'd20, 32'h0000_0000);
        offer(CMD_RESET_ALL, 5'd31, 32'hFFFF_FFFF);
        offer(CMD_RESET_ALL, 5'd0, 32'h0000_0000);
        offer(CMD_COMPLETE, 5'd16, 32'hA5A5_A5A5);
        drain();

        send_idle_pct = 17;
        recv_stall_pct <= 83;
        repeat (PHASE_ITEMS) random_item();
        drain();

        send_idle_pct = 83;
        recv_stall_pct <= 17;
        repeat (PHASE_ITEMS) random_item();
        drain();

        send_idle_pct = 0;
        recv_stall_pct <= 0;
        repeat (PHASE_ITEMS / 2) random_item();
        hold_req <= ~hold_req;
        repeat (PHASE_ITEMS - PHASE_ITEMS / 2) random_item();
        drain();
        repeat (20) @(posedge clk);

        $display("sent %0d register, %0d complete, %0d reset-one, %0d reset-all items",
                 sent_per_cmd[CMD_REGISTER], sent_per_cmd[CMD_COMPLETE],
                 sent_per_cmd[CMD_RESET_ONE], sent_per_cmd[CMD_RESET_ALL]);
        $display("%0d results checked under three stall patterns and one long output hold",
                 checked);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
